FILE: rtl/xoshiro256ss_bounded_rng_top_macros.svh
// Assertion macros for the xoshiro256** bounded generator checker.
// No dependencies.
`ifndef XOSHIRO256SS_BOUNDED_RNG_TOP_MACROS_SVH
`define XOSHIRO256SS_BOUNDED_RNG_TOP_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define XRNG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with the consequent in the next cycle
`define XRNG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/xrng_pkg.sv
// Package for the xoshiro256** bounded generator: widths, codes, helpers.
// No dependencies.
package xrng_pkg;

    localparam int WORD_W   = 64;
    localparam int HALF_W   = 32;
    localparam int NUM_SEED = 4;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W     = 72;   // op + range_max, padded to bytes
    localparam int OUT_W    = 96;   // value + upper_word

    localparam logic OP_RAW   = 1'b0;
    localparam logic OP_RANGE = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    function automatic word_t rotl(input word_t v, input int unsigned n);
        rotl = (v << n) | (v >> (WORD_W - n));
    endfunction

endpackage

FILE: rtl/xoshiro256ss_bounded_rng_top.sv
// Top level of the xoshiro256** generator with raw and unbiased ranged draws.
// Depends on xrng_pkg.
//
// A raw draw passes a draw step, then the output state. A ranged draw
// with range_max above one runs one shared restoring divider, one quotient
// bit per cycle, twice: first for the rejection threshold, then tries of a
// draw and a compare, repeated while the output is below the threshold, and
// then for the remainder. A ranged draw with range_max of zero or one returns
// zero in the cycle after accept and leaves the generator alone. The input
// is not ready while an item is at work or its result waits on the output.
// Seed writes reload the state at once.
module xoshiro256ss_bounded_rng_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Seed write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [xrng_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [xrng_pkg::WORD_W-1:0]       cfg_data,
    // Request beat: [0] op, [64:1] range_max, [71:65] zero
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [xrng_pkg::IN_W-1:0]         s_axis_tdata,
    // Result beat: [63:0] value, [95:64] upper_word
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [xrng_pkg::OUT_W-1:0]        m_axis_tdata
);
    import xrng_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_THR  = 3'd1;
    localparam logic [2:0] ST_DRAW = 3'd2;
    localparam logic [2:0] ST_TEST = 3'd3;
    localparam logic [2:0] ST_REM  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_RAW  = 3'd6;

    logic [2:0]  state_reg, state_next;
    word_t       seed_reg [NUM_SEED];
    word_t       gs_reg [NUM_SEED];
    word_t       bound_reg;
    word_t       thr_reg;
    word_t       draw_reg;
    word_t       res_reg;
    // Shared divider: remainder, dividend shift, bit count
    word_t       rem_reg;
    word_t       dvd_reg;
    logic [6:0]  cnt_reg;

    logic        in_op;
    word_t       in_max;
    word_t       draw_out;
    word_t       step_s [NUM_SEED];
    logic [WORD_W:0] rem_sh;
    logic [WORD_W:0] rem_sub;
    logic        cfg_hit;

    assign in_op  = s_axis_tdata[0];
    assign in_max = s_axis_tdata[WORD_W:1];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {res_reg[WORD_W-1:HALF_W], res_reg};
    assign cfg_hit       = cfg_valid && cfg_ready;

    // Generator output and next state
    always_comb
    begin
        word_t t;
        t         = gs_reg[1] << 17;
        draw_out  = rotl(gs_reg[1] * 64'd5, 7) * 64'd9;
        step_s[2] = gs_reg[2] ^ gs_reg[0];
        step_s[3] = gs_reg[3] ^ gs_reg[1];
        step_s[1] = gs_reg[1] ^ step_s[2];
        step_s[0] = gs_reg[0] ^ step_s[3];
        step_s[2] = step_s[2] ^ t;
        step_s[3] = rotl(step_s[3], 45);
    end

    // One restoring divide step
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[WORD_W-1]};
        rem_sub = rem_sh - {1'b0, bound_reg};
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (in_op == OP_RAW)
                        state_next = ST_RAW;
                    else if (in_max <= 64'd1)
                        state_next = ST_OUT;
                    else
                        state_next = ST_THR;
                end
            end
            ST_THR:  if (cnt_reg == 7'd63) state_next = ST_DRAW;
            ST_DRAW: state_next = ST_TEST;
            ST_TEST: state_next = (draw_reg < thr_reg) ? ST_DRAW : ST_REM;
            ST_REM:  if (cnt_reg == 7'd63) state_next = ST_OUT;
            ST_RAW:  state_next = ST_OUT;
            ST_OUT:  if (m_axis_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < NUM_SEED; i++)
            begin
                seed_reg[i] <= '0;
                gs_reg[i]   <= (i == 0) ? 64'd1 : 64'd0;
            end
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // Seed write reloads the whole state
            if (cfg_hit)
            begin
                for (int i = 0; i < NUM_SEED; i++)
                    gs_reg[i] <= (cfg_index == i[1:0]) ? cfg_data : seed_reg[i];
                seed_reg[cfg_index] <= cfg_data;
                if (cfg_data == '0)
                begin
                    // all-zero check on the words that remain
                    if (((cfg_index == 2'd0) ? '0 : seed_reg[0]) == '0 &&
                        ((cfg_index == 2'd1) ? '0 : seed_reg[1]) == '0 &&
                        ((cfg_index == 2'd2) ? '0 : seed_reg[2]) == '0 &&
                        ((cfg_index == 2'd3) ? '0 : seed_reg[3]) == '0)
                        gs_reg[0] <= 64'd1;
                end
            end
            else if (state_reg == ST_RAW || state_reg == ST_DRAW)
            begin
                for (int i = 0; i < NUM_SEED; i++)
                    gs_reg[i] <= step_s[i];
            end
            if (state_reg == ST_IDLE || state_reg == ST_TEST)
                cnt_reg <= '0;
            else if (state_reg == ST_THR || state_reg == ST_REM)
                cnt_reg <= cnt_reg + 7'd1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                bound_reg <= in_max;
                res_reg   <= '0;
                rem_reg   <= '0;
                dvd_reg   <= '0 - in_max;
            end
            ST_THR:
            begin
                dvd_reg <= dvd_reg << 1;
                rem_reg <= rem_sub[WORD_W] ? rem_sh[WORD_W-1:0] : rem_sub[WORD_W-1:0];
                if (cnt_reg == 7'd63)
                    thr_reg <= rem_sub[WORD_W] ? rem_sh[WORD_W-1:0]
                                               : rem_sub[WORD_W-1:0];
            end
            ST_DRAW:
                draw_reg <= draw_out;
            ST_TEST:
            begin
                rem_reg <= '0;
                dvd_reg <= draw_reg;
            end
            ST_REM:
            begin
                dvd_reg <= dvd_reg << 1;
                rem_reg <= rem_sub[WORD_W] ? rem_sh[WORD_W-1:0] : rem_sub[WORD_W-1:0];
                if (cnt_reg == 7'd63)
                    res_reg <= rem_sub[WORD_W] ? rem_sh[WORD_W-1:0]
                                               : rem_sub[WORD_W-1:0];
            end
            ST_RAW:
                res_reg <= draw_out;
            default:
                res_reg <= res_reg;
        endcase
    end

endmodule

FILE: rtl/xrng_checker.sv
// Port-level checker for the xoshiro256** bounded generator, with its bind.
// Depends on xoshiro256ss_bounded_rng_top_macros.svh.
`include "xoshiro256ss_bounded_rng_top_macros.svh"

module xrng_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);
    // Result beat upper field mirrors value bits 63..32
    `XRNG_ASSERT_IMP(a_upper, clk, rst_n, m_axis_tvalid,
        m_axis_tdata[95:64] == m_axis_tdata[63:32], "upper_word mismatch")
    // No request taken while a result waits
    `XRNG_ASSERT_IMP(a_excl, clk, rst_n, m_axis_tvalid, !s_axis_tready,
        "ready while result pending")
    // Ready drops in the cycle after an accepted request
    `XRNG_ASSERT_NEXT(a_lat, clk, rst_n, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "ready right after accept")
    // Stalled result holds
    `XRNG_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule

bind xoshiro256ss_bounded_rng_top xrng_checker u_xrng_checker
(
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
